[design/oaht_pkg.sv]
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Shared widths, codes and payload types of the hash table unit.
// ----------------------------------------------------------------------------
package oaht_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int MAX_PROBES  = 8;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int SIZE_W      = 9;
	localparam int PCNT_W      = 4;
	localparam int OFFS_W      = 64;
	localparam int OFF_W       = 8;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W      = $clog2(KEY_W + 1);
	localparam int CFG_IDX_W   = 2;

	localparam logic [OFFS_W-1:0] OFFS_RESET = 64'h0807_0605_0403_0201;

	typedef enum logic [1:0] {
		K_FIND   = 2'd0,
		K_INSERT = 2'd1,
		K_REMOVE = 2'd2,
		K_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_PRESENT  = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFFS  = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} oaht_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot_index;
		logic [VAL_W-1:0]  found_value;
		logic [CNT_W-1:0]  entry_count;
	} oaht_rsp_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [KEY_W-1:0]  dividend;
	} mod_cmd_t;

	typedef struct packed {
		logic              en;
		logic              clr;
		logic [SLOT_W-1:0] addr;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} store_wr_t;

endpackage

[design/oaht_mod.sv]
// ----------------------------------------------------------------------------
// Hash table modulo unit
// Restoring remainder unit, one dividend bit per cycle, left aligned.
// ----------------------------------------------------------------------------
module oaht_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  oaht_pkg::mod_cmd_t       cmd,
	input  logic [oaht_pkg::SIZE_W-1:0] divisor,
	output logic                     done,
	output logic [oaht_pkg::SIZE_W-1:0] rem
);
	import oaht_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] cnt_q;
	logic [SIZE_W-1:0] rem_q;
	logic [KEY_W-1:0]  dv_q;
	logic [SIZE_W:0]   trial;

	assign trial = {rem_q, dv_q[KEY_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= '0;
			dv_q  <= cmd.dividend;
		end else if (busy_q && cnt_q != '0) begin
			dv_q <= {dv_q[KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= SIZE_W'(trial - {1'b0, divisor});
			end else begin
				rem_q <= SIZE_W'(trial);
			end
		end
	end

	assign done = busy_q && cnt_q == '0;
	assign rem  = rem_q;

endmodule

[design/oaht_store.sv]
// ----------------------------------------------------------------------------
// Hash table slot store
// Key and value memories with registered read, and the occupied flags.
// ----------------------------------------------------------------------------
module oaht_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [oaht_pkg::SLOT_W-1:0] rd_addr,
	input  oaht_pkg::store_wr_t         wr,
	output logic                        occ_rd,
	output logic [oaht_pkg::KEY_W-1:0]  key_rd,
	output logic [oaht_pkg::VAL_W-1:0]  val_rd
);
	import oaht_pkg::*;

	logic [TABLE_DEPTH-1:0] occ_q;
	logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
	logic [VAL_W-1:0]       val_mem [TABLE_DEPTH];
	logic                   occ_rd_q;
	logic [KEY_W-1:0]       key_rd_q;
	logic [VAL_W-1:0]       val_rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q    <= '0;
			occ_rd_q <= 1'b0;
		end else begin
			occ_rd_q <= occ_q[rd_addr];
			if (wr.en) begin
				occ_q[wr.addr] <= 1'b1;
			end else if (wr.clr) begin
				occ_q[wr.addr] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			key_mem[wr.addr] <= wr.key;
			val_mem[wr.addr] <= wr.value;
		end
		key_rd_q <= key_mem[rd_addr];
		val_rd_q <= val_mem[rd_addr];
	end

	assign occ_rd = occ_rd_q;
	assign key_rd = key_rd_q;
	assign val_rd = val_rd_q;

endmodule

[design/open_addressing_hash_table_unit.sv]
// ----------------------------------------------------------------------------
// Open-addressing hash table unit
// Find, insert and remove of keys over a configurable probe sequence.
// ----------------------------------------------------------------------------
// Flow: an unused kind goes straight to the response; any other request first reduces
// its key to a home slot, then examines the home slot and at most eight probes in turn.
// The first request after reset or after a table size or offset write first reduces
// the eight offsets through the shared modulo unit.
// One request at a time: the next is not taken until the response has been issued.
// Reset empties the table and loads the default size, probe count and offsets.
module open_addressing_hash_table_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  oaht_pkg::oaht_req_t            req,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output oaht_pkg::oaht_rsp_t            rsp,
	input  logic                           cfg_we,
	input  logic [oaht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [oaht_pkg::OFFS_W-1:0]    cfg_data
);
	import oaht_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,
		S_MOD  = 6'b000100,
		S_ADDR = 6'b001000,
		S_CHK  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	localparam int RED_W = $clog2(MAX_PROBES);

	state_t            state_q, state_d;
	logic [SIZE_W-1:0] tsz_q;
	logic [PCNT_W-1:0] pcnt_q;
	logic [OFFS_W-1:0] offs_q;
	logic              dirty_q;
	logic [RED_W-1:0]  red_idx_q;
	logic [SLOT_W-1:0] roff_q [MAX_PROBES];
	logic [CNT_W-1:0]  count_q;

	logic [1:0]        kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [SLOT_W-1:0] home_q;
	logic [PCNT_W-1:0] p_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] free_q;
	logic              free_vld_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [VAL_W-1:0]  res_val_q;

	logic              rsp_valid_q;
	oaht_rsp_t         rsp_q;

	logic              req_acc;
	logic              last_probe;
	logic [SIZE_W-1:0] eff_size;
	logic [PCNT_W-1:0] eff_probes;
	mod_cmd_t          mod_cmd;
	logic              mod_done;
	logic [SIZE_W-1:0] mod_rem;
	logic [SIZE_W-1:0] wrap_sum;
	logic [SLOT_W-1:0] slot_c;
	store_wr_t         wr;
	logic              occ_rd;
	logic [KEY_W-1:0]  key_rd;
	logic [VAL_W-1:0]  val_rd;
	logic              hit;
	logic              free_any;
	logic [SLOT_W-1:0] free_c;

	assign req_stall = state_q != S_IDLE;
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		if (tsz_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (tsz_q > SIZE_W'(TABLE_DEPTH)) begin
			eff_size = SIZE_W'(TABLE_DEPTH);
		end else begin
			eff_size = tsz_q;
		end
		if (pcnt_q > PCNT_W'(MAX_PROBES)) begin
			eff_probes = PCNT_W'(MAX_PROBES);
		end else begin
			eff_probes = pcnt_q;
		end
	end

	// The shared modulo unit reduces the offsets after a table size or offset write and then
	// the key of every request but an unused kind.
	always_comb begin
		mod_cmd.start    = 1'b0;
		mod_cmd.steps    = STEP_W'(KEY_W);
		mod_cmd.dividend = key_q;
		if (state_q == S_IDLE && req_acc && req.kind != K_NONE) begin
			mod_cmd.start = 1'b1;
			if (dirty_q) begin
				mod_cmd.steps    = STEP_W'(OFF_W);
				mod_cmd.dividend = {offs_q[0 +: OFF_W], (KEY_W-OFF_W)'(0)};
			end else begin
				mod_cmd.dividend = req.key;
			end
		end else if (state_q == S_RED && mod_done) begin
			mod_cmd.start = 1'b1;
			if (red_idx_q != RED_W'(MAX_PROBES - 1)) begin
				mod_cmd.steps    = STEP_W'(OFF_W);
				mod_cmd.dividend = {offs_q[OFF_W * (red_idx_q + 1'b1) +: OFF_W],
					(KEY_W-OFF_W)'(0)};
			end
		end
	end

	oaht_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (mod_cmd),
		.divisor (eff_size),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign wrap_sum = {1'b0, home_q} + {1'b0, roff_q[RED_W'(p_q - 1'b1)]};

	always_comb begin
		if (p_q == '0) begin
			slot_c = home_q;
		end else if (wrap_sum >= eff_size) begin
			slot_c = SLOT_W'(wrap_sum - eff_size);
		end else begin
			slot_c = SLOT_W'(wrap_sum);
		end
	end

	assign hit        = occ_rd && key_rd == key_q;
	assign free_any   = free_vld_q || !occ_rd;
	assign free_c     = free_vld_q ? free_q : slot_q;
	assign last_probe = p_q == eff_probes;

	always_comb begin
		wr.en    = 1'b0;
		wr.clr   = 1'b0;
		wr.addr  = slot_q;
		wr.key   = key_q;
		wr.value = val_q;
		if (state_q == S_CHK) begin
			if (hit) begin
				wr.clr = kind_q == K_REMOVE;
			end else if (last_probe && kind_q == K_INSERT && free_any) begin
				wr.en   = 1'b1;
				wr.addr = free_c;
			end
		end
	end

	oaht_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (slot_c),
		.wr      (wr),
		.occ_rd  (occ_rd),
		.key_rd  (key_rd),
		.val_rd  (val_rd)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					if (req.kind == K_NONE) begin
						state_d = S_DONE;
					end else if (dirty_q) begin
						state_d = S_RED;
					end else begin
						state_d = S_MOD;
					end
				end
			end
			S_RED: begin
				if (mod_done && red_idx_q == RED_W'(MAX_PROBES - 1)) begin
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (hit || last_probe) begin
					state_d = S_DONE;
				end else begin
					state_d = S_ADDR;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tsz_q       <= SIZE_W'(TABLE_DEPTH);
			pcnt_q      <= PCNT_W'(MAX_PROBES);
			offs_q      <= OFFS_RESET;
			dirty_q     <= 1'b1;
			red_idx_q   <= '0;
			count_q     <= '0;
			free_vld_q  <= 1'b0;
			p_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_TABLE_SIZE: begin
						tsz_q   <= cfg_data[SIZE_W-1:0];
						dirty_q <= 1'b1;
					end
					CFG_PROBE_COUNT: begin
						pcnt_q <= cfg_data[PCNT_W-1:0];
					end
					CFG_PROBE_OFFS: begin
						offs_q  <= cfg_data;
						dirty_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (state_q == S_IDLE) begin
				red_idx_q <= '0;
			end else if (state_q == S_RED && mod_done) begin
				red_idx_q <= red_idx_q + 1'b1;
				if (red_idx_q == RED_W'(MAX_PROBES - 1)) begin
					dirty_q <= 1'b0;
				end
			end
			if (state_q == S_MOD && mod_done) begin
				p_q        <= '0;
				free_vld_q <= 1'b0;
			end
			if (state_q == S_CHK) begin
				p_q <= p_q + 1'b1;
				if (!occ_rd && !free_vld_q) begin
					free_vld_q <= 1'b1;
				end
				if (wr.en) begin
					count_q <= count_q + 1'b1;
				end else if (wr.clr && count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q     <= req.kind;
			key_q      <= req.key;
			val_q      <= req.value;
			status_q   <= ST_NOTFOUND;
			res_slot_q <= '0;
			res_val_q  <= '0;
		end
		if (state_q == S_RED && mod_done) begin
			roff_q[red_idx_q] <= SLOT_W'(mod_rem);
		end
		if (state_q == S_MOD && mod_done) begin
			home_q <= SLOT_W'(mod_rem);
		end
		if (state_q == S_ADDR) begin
			slot_q <= slot_c;
		end
		if (state_q == S_CHK) begin
			if (!occ_rd && !free_vld_q) begin
				free_q <= slot_q;
			end
			if (hit) begin
				res_slot_q <= slot_q;
				case (kind_q)
					K_FIND: begin
						status_q  <= ST_OK;
						res_val_q <= val_rd;
					end
					K_INSERT: begin
						status_q <= ST_PRESENT;
					end
					K_REMOVE: begin
						status_q <= ST_OK;
					end
					default: begin
						status_q <= ST_NOTFOUND;
					end
				endcase
			end else if (last_probe && kind_q == K_INSERT) begin
				if (free_any) begin
					status_q   <= ST_OK;
					res_slot_q <= free_c;
				end else begin
					status_q <= ST_FULL;
				end
			end
		end
		if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.status      <= status_q;
			rsp_q.slot_index  <= res_slot_q;
			rsp_q.found_value <= res_val_q;
			rsp_q.entry_count <= count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_home_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ADDR |-> {1'b0, home_q} < eff_size)
		else $error("home slot outside the table");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> p_q <= eff_probes)
		else $error("probe number beyond the probe count");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.en && wr.clr))
		else $error("slot written and cleared together");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !$rose(rsp_valid_q))
		else $error("response issued in the cycle after a request");

endmodule
